FILE: src/imd_pkg.sv
// Shared types, constants and helpers for the induction machine derivative unit.
// Used by every module of the block; depends on nothing.
package imd_pkg;

    // Word format of all fields and coefficients
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SAT_IN_W      = 2 * DATA_W;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = $clog2(NUM_REGS);

    // Build defaults
    localparam int BASE_SPEED_DEF    = 20578304;
    localparam int FRACTION_BITS_DEF = 16;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KS = 3'd0,
        REG_KF = 3'd1,
        REG_KW = 3'd2,
        REG_KC = 3'd3,
        REG_KD = 3'd4,
        REG_KV = 3'd5,
        REG_KT = 3'd6,
        REG_KJ = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic signed [DATA_W-1:0] ks;
        logic signed [DATA_W-1:0] kf;
        logic signed [DATA_W-1:0] kw;
        logic signed [DATA_W-1:0] kc;
        logic signed [DATA_W-1:0] kd;
        logic signed [DATA_W-1:0] kv;
        logic signed [DATA_W-1:0] kt;
        logic signed [DATA_W-1:0] kj;
    } coeff_t;

    // Coefficient terms computed in the front half and carried to the sums
    localparam int T_KS_ISD = 0;
    localparam int T_KF_FRD = 1;
    localparam int T_KV_USD = 2;
    localparam int T_KS_ISQ = 3;
    localparam int T_KF_FRQ = 4;
    localparam int T_KV_USQ = 5;
    localparam int T_KC_ISD = 6;
    localparam int T_KD_FRD = 7;
    localparam int T_KC_ISQ = 8;
    localparam int T_KD_FRQ = 9;
    localparam int T_KJ_TL  = 10;
    localparam int NUM_TERM = 11;

    // Cross products of state values, behind the terms in the product array
    localparam int X_FQW    = 11;
    localparam int X_FDW    = 12;
    localparam int X_FDISQ  = 13;
    localparam int X_FQISD  = 14;
    localparam int NUM_PROD = 15;

    // Second-level products in the back half
    localparam int M_KW_FQW  = 0;
    localparam int M_NKW_FDW = 1;
    localparam int M_NWB_FQW = 2;
    localparam int M_WB_FDW  = 3;
    localparam int M_KT_TQ   = 4;
    localparam int NUM_MPROD = 5;

    // Clamp a wide signed value to the signed word range
    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_IN_W'(Q_MAX))
        begin
            res = Q_MAX;
        end
        else if (v < SAT_IN_W'(Q_MIN))
        begin
            res = Q_MIN;
        end
        else
        begin
            res = DATA_W'(v);
        end
        return res;
    endfunction

endpackage

FILE: src/induction_machine_derivative_unit.sv
// Induction machine dq derivative unit, top level.
// Each input transaction passes through four register stages with two multiplier ranks.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset (rst_n, async, active low) empties the pipeline and clears all coefficients to zero.
// Depends on imd_pkg, imd_cfg_regs, imd_front and imd_back.
module induction_machine_derivative_unit
    import imd_pkg::*;
#(
    parameter int BASE_SPEED    = BASE_SPEED_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] stator_current_d,
    input  logic signed [DATA_W-1:0] stator_current_q,
    input  logic signed [DATA_W-1:0] rotor_flux_d,
    input  logic signed [DATA_W-1:0] rotor_flux_q,
    input  logic signed [DATA_W-1:0] rotor_speed,
    input  logic signed [DATA_W-1:0] stator_voltage_d,
    input  logic signed [DATA_W-1:0] stator_voltage_q,
    input  logic signed [DATA_W-1:0] load_torque,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] d_stator_current_d,
    output logic signed [DATA_W-1:0] d_stator_current_q,
    output logic signed [DATA_W-1:0] d_rotor_flux_d,
    output logic signed [DATA_W-1:0] d_rotor_flux_q,
    output logic signed [DATA_W-1:0] d_rotor_speed
);

    localparam int TERM_W = PROD_W - FRACTION_BITS;

    coeff_t                   coeff;
    logic                     front_ready;
    logic                     mid_valid;
    logic                     mid_ready;
    logic signed [TERM_W-1:0] mid_terms [NUM_TERM];
    logic signed [DATA_W-1:0] mid_fq_w;
    logic signed [DATA_W-1:0] mid_fd_w;
    logic signed [DATA_W-1:0] mid_torque;

    // Coefficient registers
    imd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeff     (coeff)
    );

    // First multiplier rank and intermediate saturation
    imd_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .coeff            (coeff),
        .up_valid         (in_valid),
        .up_ready         (front_ready),
        .stator_current_d (stator_current_d),
        .stator_current_q (stator_current_q),
        .rotor_flux_d     (rotor_flux_d),
        .rotor_flux_q     (rotor_flux_q),
        .rotor_speed      (rotor_speed),
        .stator_voltage_d (stator_voltage_d),
        .stator_voltage_q (stator_voltage_q),
        .load_torque      (load_torque),
        .down_valid       (mid_valid),
        .down_ready       (mid_ready),
        .terms            (mid_terms),
        .fq_w             (mid_fq_w),
        .fd_w             (mid_fd_w),
        .torque           (mid_torque)
    );

    // Second multiplier rank, sums and output register
    imd_back #(
        .BASE_SPEED    (BASE_SPEED),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .coeff              (coeff),
        .up_valid           (mid_valid),
        .up_ready           (mid_ready),
        .terms              (mid_terms),
        .fq_w               (mid_fq_w),
        .fd_w               (mid_fd_w),
        .torque             (mid_torque),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .d_stator_current_d (d_stator_current_d),
        .d_stator_current_q (d_stator_current_q),
        .d_rotor_flux_d     (d_rotor_flux_d),
        .d_rotor_flux_q     (d_rotor_flux_q),
        .d_rotor_speed      (d_rotor_speed)
    );

    assign in_stall = !front_ready;

`ifndef ASSERT_OFF
    // A free-running output never backs up into the input
    a_no_stall_when_flowing: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall
    ) else $error("input stalled while output is free");

    // An accepted transaction reaches the output while the output stays unstalled
    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        |=> ##1 out_valid
    ) else $error("result missing after pipeline latency");
`endif

endmodule

FILE: src/imd_cfg_regs.sv
// Coefficient register file of the induction machine derivative unit.
// Depends on imd_pkg for the register indexes and the coefficient struct.
module imd_cfg_regs
    import imd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output coeff_t               coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    // Always able to take a write
    assign cfg_ready = 1'b1;

    // Decode the index and update one coefficient
    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_KS:  coeff_next.ks = cfg_data;
                REG_KF:  coeff_next.kf = cfg_data;
                REG_KW:  coeff_next.kw = cfg_data;
                REG_KC:  coeff_next.kc = cfg_data;
                REG_KD:  coeff_next.kd = cfg_data;
                REG_KV:  coeff_next.kv = cfg_data;
                REG_KT:  coeff_next.kt = cfg_data;
                REG_KJ:  coeff_next.kj = cfg_data;
                default: coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

endmodule

FILE: src/imd_front.sv
// Front half of the derivative pipeline: all first-level products (stage 1),
// then rounding, speed-flux and torque saturation (stage 2). Depends on imd_pkg.
module imd_front
    import imd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  coeff_t                          coeff,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic signed [DATA_W-1:0]        stator_current_d,
    input  logic signed [DATA_W-1:0]        stator_current_q,
    input  logic signed [DATA_W-1:0]        rotor_flux_d,
    input  logic signed [DATA_W-1:0]        rotor_flux_q,
    input  logic signed [DATA_W-1:0]        rotor_speed,
    input  logic signed [DATA_W-1:0]        stator_voltage_d,
    input  logic signed [DATA_W-1:0]        stator_voltage_q,
    input  logic signed [DATA_W-1:0]        load_torque,
    output logic                            down_valid,
    input  logic                            down_ready,
    output logic signed [PROD_W-FRACTION_BITS-1:0] terms [NUM_TERM],
    output logic signed [DATA_W-1:0]        fq_w,
    output logic signed [DATA_W-1:0]        fd_w,
    output logic signed [DATA_W-1:0]        torque
);

    localparam int TERM_W = PROD_W - FRACTION_BITS;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

    logic                     en1;
    logic                     en2;
    logic                     v1_reg;
    logic                     v1_next;
    logic                     v2_reg;
    logic                     v2_next;
    logic signed [DATA_W-1:0] op_a [NUM_PROD];
    logic signed [DATA_W-1:0] op_b [NUM_PROD];
    logic signed [PROD_W-1:0] prod_next [NUM_PROD];
    logic signed [PROD_W-1:0] prod_reg [NUM_PROD];
    logic signed [PROD_W-1:0] rnd_sum [NUM_PROD];
    logic signed [TERM_W-1:0] rnd_val [NUM_PROD];
    logic signed [TERM_W:0]   tq_diff;
    logic signed [TERM_W-1:0] term_next [NUM_TERM];
    logic signed [TERM_W-1:0] term_reg [NUM_TERM];
    logic signed [DATA_W-1:0] fqw_next;
    logic signed [DATA_W-1:0] fqw_reg;
    logic signed [DATA_W-1:0] fdw_next;
    logic signed [DATA_W-1:0] fdw_reg;
    logic signed [DATA_W-1:0] tq_next;
    logic signed [DATA_W-1:0] tq_reg;

    // Advance a stage when it is empty or its contents move on
    assign en2      = !v2_reg || down_ready;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;
    assign v1_next  = en1 ? up_valid : v1_reg;
    assign v2_next  = en2 ? v1_reg : v2_reg;

    // Route operand pairs to the product array
    always_comb
    begin
        op_a[T_KS_ISD] = coeff.ks;     op_b[T_KS_ISD] = stator_current_d;
        op_a[T_KF_FRD] = coeff.kf;     op_b[T_KF_FRD] = rotor_flux_d;
        op_a[T_KV_USD] = coeff.kv;     op_b[T_KV_USD] = stator_voltage_d;
        op_a[T_KS_ISQ] = coeff.ks;     op_b[T_KS_ISQ] = stator_current_q;
        op_a[T_KF_FRQ] = coeff.kf;     op_b[T_KF_FRQ] = rotor_flux_q;
        op_a[T_KV_USQ] = coeff.kv;     op_b[T_KV_USQ] = stator_voltage_q;
        op_a[T_KC_ISD] = coeff.kc;     op_b[T_KC_ISD] = stator_current_d;
        op_a[T_KD_FRD] = coeff.kd;     op_b[T_KD_FRD] = rotor_flux_d;
        op_a[T_KC_ISQ] = coeff.kc;     op_b[T_KC_ISQ] = stator_current_q;
        op_a[T_KD_FRQ] = coeff.kd;     op_b[T_KD_FRQ] = rotor_flux_q;
        op_a[T_KJ_TL]  = coeff.kj;     op_b[T_KJ_TL]  = load_torque;
        op_a[X_FQW]    = rotor_flux_q; op_b[X_FQW]    = rotor_speed;
        op_a[X_FDW]    = rotor_flux_d; op_b[X_FDW]    = rotor_speed;
        op_a[X_FDISQ]  = rotor_flux_d; op_b[X_FDISQ]  = stator_current_q;
        op_a[X_FQISD]  = rotor_flux_q; op_b[X_FQISD]  = stator_current_d;
    end

    // Stage 1: one signed multiply per product
    always_comb
    begin
        for (int i = 0; i < NUM_PROD; i++)
        begin
            prod_next[i] = op_a[i] * op_b[i];
        end
    end

    // Stage 2: round half up, then clamp the state cross products
    always_comb
    begin
        for (int i = 0; i < NUM_PROD; i++)
        begin
            rnd_sum[i] = prod_reg[i] + HALF;
            rnd_val[i] = TERM_W'(rnd_sum[i] >>> FRACTION_BITS);
        end
        for (int i = 0; i < NUM_TERM; i++)
        begin
            term_next[i] = rnd_val[i];
        end
        fqw_next = sat_q(SAT_IN_W'(rnd_val[X_FQW]));
        fdw_next = sat_q(SAT_IN_W'(rnd_val[X_FDW]));
        tq_diff  = (TERM_W+1)'(rnd_val[X_FDISQ]) - (TERM_W+1)'(rnd_val[X_FQISD]);
        tq_next  = sat_q(SAT_IN_W'(tq_diff));
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Load payload of each stage on advance
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg <= prod_next;
        end
        if (en2)
        begin
            term_reg <= term_next;
            fqw_reg  <= fqw_next;
            fdw_reg  <= fdw_next;
            tq_reg   <= tq_next;
        end
    end

    assign down_valid = v2_reg;
    assign terms      = term_reg;
    assign fq_w       = fqw_reg;
    assign fd_w       = fdw_reg;
    assign torque     = tq_reg;

endmodule

FILE: src/imd_back.sv
// Back half of the derivative pipeline: coefficient times speed-flux and torque
// products (stage 3), then rounding, sums and output saturation (stage 4). Depends on imd_pkg.
module imd_back
    import imd_pkg::*;
#(
    parameter int BASE_SPEED    = BASE_SPEED_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  coeff_t                          coeff,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic signed [PROD_W-FRACTION_BITS-1:0] terms [NUM_TERM],
    input  logic signed [DATA_W-1:0]        fq_w,
    input  logic signed [DATA_W-1:0]        fd_w,
    input  logic signed [DATA_W-1:0]        torque,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [DATA_W-1:0]        d_stator_current_d,
    output logic signed [DATA_W-1:0]        d_stator_current_q,
    output logic signed [DATA_W-1:0]        d_rotor_flux_d,
    output logic signed [DATA_W-1:0]        d_rotor_flux_q,
    output logic signed [DATA_W-1:0]        d_rotor_speed
);

    localparam int TERM_W  = PROD_W - FRACTION_BITS;
    localparam int SUM_W   = TERM_W + 2;
    localparam int MPROD_W = 2 * DATA_W + 1;
    localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) << (FRACTION_BITS - 1);
    localparam logic signed [DATA_W:0]   WB     = (DATA_W+1)'(BASE_SPEED);
    localparam logic signed [DATA_W:0]   NEG_WB = -WB;

    logic                      en3;
    logic                      en4;
    logic                      v3_reg;
    logic                      v3_next;
    logic                      v4_reg;
    logic                      v4_next;
    logic signed [DATA_W:0]    neg_kw;
    logic signed [DATA_W:0]    mop_a [NUM_MPROD];
    logic signed [DATA_W-1:0]  mop_b [NUM_MPROD];
    logic signed [MPROD_W-1:0] mprod_full [NUM_MPROD];
    logic signed [PROD_W-1:0]  mprod_reg [NUM_MPROD];
    logic signed [TERM_W-1:0]  term_reg [NUM_TERM];
    logic signed [PROD_W-1:0]  mrnd_sum [NUM_MPROD];
    logic signed [TERM_W-1:0]  mt [NUM_MPROD];
    logic signed [SUM_W-1:0]   sum [5];
    logic signed [DATA_W-1:0]  isd_next;
    logic signed [DATA_W-1:0]  isq_next;
    logic signed [DATA_W-1:0]  frd_next;
    logic signed [DATA_W-1:0]  frq_next;
    logic signed [DATA_W-1:0]  w_next;
    logic signed [DATA_W-1:0]  isd_reg;
    logic signed [DATA_W-1:0]  isq_reg;
    logic signed [DATA_W-1:0]  frd_reg;
    logic signed [DATA_W-1:0]  frq_reg;
    logic signed [DATA_W-1:0]  w_reg;

    // Advance a stage when it is empty or its contents move on
    assign en4      = !v4_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign up_ready = en3;
    assign v3_next  = en3 ? up_valid : v3_reg;
    assign v4_next  = en4 ? v3_reg : v4_reg;

    // Negate the speed-flux coefficient exactly, one bit wider
    assign neg_kw = -((DATA_W+1)'(coeff.kw));

    // Stage 3: coefficient products of the clamped intermediates
    always_comb
    begin
        mop_a[M_KW_FQW]  = (DATA_W+1)'(coeff.kw); mop_b[M_KW_FQW]  = fq_w;
        mop_a[M_NKW_FDW] = neg_kw;                mop_b[M_NKW_FDW] = fd_w;
        mop_a[M_NWB_FQW] = NEG_WB;                mop_b[M_NWB_FQW] = fq_w;
        mop_a[M_WB_FDW]  = WB;                    mop_b[M_WB_FDW]  = fd_w;
        mop_a[M_KT_TQ]   = (DATA_W+1)'(coeff.kt); mop_b[M_KT_TQ]   = torque;
        for (int i = 0; i < NUM_MPROD; i++)
        begin
            mprod_full[i] = mop_a[i] * mop_b[i];
        end
    end

    // Stage 4: round, add the terms of each derivative, clamp
    always_comb
    begin
        for (int i = 0; i < NUM_MPROD; i++)
        begin
            mrnd_sum[i] = mprod_reg[i] + HALF;
            mt[i]       = TERM_W'(mrnd_sum[i] >>> FRACTION_BITS);
        end
        sum[0] = SUM_W'(term_reg[T_KS_ISD]) + SUM_W'(term_reg[T_KF_FRD])
               + SUM_W'(mt[M_KW_FQW]) + SUM_W'(term_reg[T_KV_USD]);
        sum[1] = SUM_W'(term_reg[T_KS_ISQ]) + SUM_W'(mt[M_NKW_FDW])
               + SUM_W'(term_reg[T_KF_FRQ]) + SUM_W'(term_reg[T_KV_USQ]);
        sum[2] = SUM_W'(term_reg[T_KC_ISD]) + SUM_W'(term_reg[T_KD_FRD])
               + SUM_W'(mt[M_NWB_FQW]);
        sum[3] = SUM_W'(term_reg[T_KC_ISQ]) + SUM_W'(mt[M_WB_FDW])
               + SUM_W'(term_reg[T_KD_FRQ]);
        sum[4] = SUM_W'(mt[M_KT_TQ]) - SUM_W'(term_reg[T_KJ_TL]);
        isd_next = sat_q(SAT_IN_W'(sum[0]));
        isq_next = sat_q(SAT_IN_W'(sum[1]));
        frd_next = sat_q(SAT_IN_W'(sum[2]));
        frq_next = sat_q(SAT_IN_W'(sum[3]));
        w_next   = sat_q(SAT_IN_W'(sum[4]));
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Load payload of each stage on advance
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < NUM_MPROD; i++)
            begin
                mprod_reg[i] <= mprod_full[i][PROD_W-1:0];
            end
            term_reg <= terms;
        end
        if (en4)
        begin
            isd_reg <= isd_next;
            isq_reg <= isq_next;
            frd_reg <= frd_next;
            frq_reg <= frq_next;
            w_reg   <= w_next;
        end
    end

    assign out_valid          = v4_reg;
    assign d_stator_current_d = isd_reg;
    assign d_stator_current_q = isq_reg;
    assign d_rotor_flux_d     = frd_reg;
    assign d_rotor_flux_q     = frq_reg;
    assign d_rotor_speed      = w_reg;

endmodule

FILE: tb/tb_induction_machine_derivative_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for induction_machine_derivative_unit: predicts the five dq derivatives
// for every accepted transaction and compares them with the results at the output channel.
// Depends on imd_pkg and the RTL of the block only.
module tb_induction_machine_derivative_unit;
    import imd_pkg::*;

    localparam int     FRAC           = FRACTION_BITS_DEF;
    localparam longint BASE_SPD       = BASE_SPEED_DEF;
    localparam longint HALF_LSB       = longint'(1) << (FRAC - 1);
    localparam longint WORD_MAX       = 64'sd2147483647;
    localparam longint WORD_MIN       = -64'sd2147483648;
    localparam int     WATCHDOG_LIMIT = 1000;

    // One machine state and excitation sample
    typedef struct packed {
        logic signed [DATA_W-1:0] isd;
        logic signed [DATA_W-1:0] isq;
        logic signed [DATA_W-1:0] frd;
        logic signed [DATA_W-1:0] frq;
        logic signed [DATA_W-1:0] spd;
        logic signed [DATA_W-1:0] usd;
        logic signed [DATA_W-1:0] usq;
        logic signed [DATA_W-1:0] tl;
    } machine_in_t;

    // The five state derivatives of one sample
    typedef struct packed {
        logic signed [DATA_W-1:0] d_isd;
        logic signed [DATA_W-1:0] d_isq;
        logic signed [DATA_W-1:0] d_frd;
        logic signed [DATA_W-1:0] d_frq;
        logic signed [DATA_W-1:0] d_spd;
    } derivs_t;

    // Coefficients in register order: Ks, Kf, Kw, Kc, Kd, Kv, Kt, Kj
    typedef logic [DATA_W-1:0] coeff_set_t [NUM_REGS];

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    machine_in_t          in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    derivs_t              out_item;

    logic signed [DATA_W-1:0] coeff_now [NUM_REGS];
    machine_in_t              pending_items [$];
    derivs_t                  expected_derivs [$];
    int                       idle_pct     = 35;
    int                       error_count  = 0;
    int                       quiet_cycles = 0;

    induction_machine_derivative_unit #(
        .BASE_SPEED    (BASE_SPEED_DEF),
        .FRACTION_BITS (FRACTION_BITS_DEF)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .stator_current_d   (in_item.isd),
        .stator_current_q   (in_item.isq),
        .rotor_flux_d       (in_item.frd),
        .rotor_flux_q       (in_item.frq),
        .rotor_speed        (in_item.spd),
        .stator_voltage_d   (in_item.usd),
        .stator_voltage_q   (in_item.usq),
        .load_torque        (in_item.tl),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .d_stator_current_d (out_item.d_isd),
        .d_stator_current_q (out_item.d_isq),
        .d_rotor_flux_d     (out_item.d_frd),
        .d_rotor_flux_q     (out_item.d_frq),
        .d_rotor_speed      (out_item.d_spd)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Round a full product to the word's fraction bits, half up
    function automatic longint round_q(input longint p);
        return (p + HALF_LSB) >>> FRAC;
    endfunction

    function automatic longint clamp_q(input longint v);
        if (v > WORD_MAX)
        begin
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // Evaluate the dq machine derivatives with the current coefficients
    function automatic derivs_t predict_derivs(input machine_in_t x);
        longint isd, isq, frd, frq, spd, usd, usq, tl;
        longint ks, kf, kw, kc, kd, kv, kt, kj;
        longint fq_w, fd_w, torque;
        longint s_isd, s_isq, s_frd, s_frq, s_spd;
        derivs_t y;
        isd = $signed(x.isd);
        isq = $signed(x.isq);
        frd = $signed(x.frd);
        frq = $signed(x.frq);
        spd = $signed(x.spd);
        usd = $signed(x.usd);
        usq = $signed(x.usq);
        tl  = $signed(x.tl);
        ks  = coeff_now[REG_KS];
        kf  = coeff_now[REG_KF];
        kw  = coeff_now[REG_KW];
        kc  = coeff_now[REG_KC];
        kd  = coeff_now[REG_KD];
        kv  = coeff_now[REG_KV];
        kt  = coeff_now[REG_KT];
        kj  = coeff_now[REG_KJ];
        fq_w   = clamp_q(round_q(frq * spd));
        fd_w   = clamp_q(round_q(frd * spd));
        torque = clamp_q(round_q(frd * isq) - round_q(frq * isd));
        s_isd = round_q(ks * isd) + round_q(kf * frd) + round_q(kw * fq_w) + round_q(kv * usd);
        s_isq = round_q(ks * isq) + round_q((-kw) * fd_w) + round_q(kf * frq)
              + round_q(kv * usq);
        s_frd = round_q(kc * isd) + round_q(kd * frd) + round_q((-BASE_SPD) * fq_w);
        s_frq = round_q(kc * isq) + round_q(BASE_SPD * fd_w) + round_q(kd * frq);
        s_spd = round_q(kt * torque) - round_q(kj * tl);
        y.d_isd = DATA_W'(clamp_q(s_isd));
        y.d_isq = DATA_W'(clamp_q(s_isq));
        y.d_frd = DATA_W'(clamp_q(s_frd));
        y.d_frq = DATA_W'(clamp_q(s_frq));
        y.d_spd = DATA_W'(clamp_q(s_spd));
        return y;
    endfunction

    // Mix of rails, zero, full-range words and typical per-unit magnitudes
    function automatic logic [DATA_W-1:0] random_q();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4, 5: return $urandom();
            default: return $urandom_range(524288) - 262144;  // within +-4.0
        endcase
    endfunction

    task automatic push_item(input logic [DATA_W-1:0] isd, isq, frd, frq,
                             input logic [DATA_W-1:0] spd, usd, usq, tl);
        machine_in_t x;
        x = '{isd, isq, frd, frq, spd, usd, usq, tl};
        pending_items.push_back(x);
    endtask

    task automatic push_uniform(input logic [DATA_W-1:0] v);
        push_item(v, v, v, v, v, v, v, v);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            push_item(random_q(), random_q(), random_q(), random_q(),
                      random_q(), random_q(), random_q(), random_q());
        end
    endtask

    // Write all coefficient registers, valid held high across the burst
    task automatic load_coeffs(input coeff_set_t vals);
        @(posedge clk);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_e'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            coeff_now[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued sample is sent and every result has arrived
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_derivs.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want, got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s expected %0d got %0d", $time, name,
                     $signed(want), $signed(got));
        end
    endtask

    // Driver: record accepted transactions, present the next sample or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_derivs.push_back(predict_derivs(in_item));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        derivs_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_derivs.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with no prediction pending", $time);
                end
                else
                begin
                    want = expected_derivs.pop_front();
                    check_field("d_stator_current_d", want.d_isd, out_item.d_isd);
                    check_field("d_stator_current_q", want.d_isq, out_item.d_isq);
                    check_field("d_rotor_flux_d", want.d_frd, out_item.d_frd);
                    check_field("d_rotor_flux_q", want.d_frq, out_item.d_frq);
                    check_field("d_rotor_speed", want.d_spd, out_item.d_spd);
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        coeff_set_t cs;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            coeff_now[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Coefficients at reset: only the base speed path is live; rails saturate speed-flux
        push_uniform(Q_MAX);
        push_uniform(Q_MIN);
        push_uniform('0);
        push_random(50);
        drain();

        // Half-unit coefficients: rounding ties go up for both signs
        cs = '{32768, 32768, 32768, 32768, 32768, 32768, 32768, 32768};
        load_coeffs(cs);
        push_uniform(1);
        push_uniform(-1);
        push_uniform(3);
        push_uniform(-3);
        push_item(1, -1, 3, -3, 1, -1, 3, -3);
        drain();

        // Largest coefficients: positive torque saturation and sum saturation in both directions
        cs = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
        load_coeffs(cs);
        push_uniform(Q_MAX);
        push_uniform(Q_MIN);
        push_item(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        push_item(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        drain();

        // Most negative coefficients: negated Kw reaches 2^31
        cs = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN};
        load_coeffs(cs);
        push_uniform(Q_MAX);
        push_uniform(Q_MIN);
        push_item(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        push_uniform('0);
        drain();

        // Typical machine coefficients, a long stretch at full rate
        cs = '{-19661, 13107, 32768, 3277, -3277, 131072, 65536, 32768};
        load_coeffs(cs);
        idle_pct = 0;
        push_random(400);
        drain();
        idle_pct = 35;

        // Random coefficient sets with throttled channels
        for (int p = 0; p < 5; p++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cs[i] = random_q();
            end
            load_coeffs(cs);
            push_random(200);
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_derivs.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
